// ----- design/ssic_pkg.sv -----
// ----------------------------------------------------------------------------
// ssic_pkg
// Shared types and constants of the sparse set intersection counter.
// ----------------------------------------------------------------------------
`default_nettype none

package ssic_pkg;

  // Width of an element value on the item channel.
  localparam int unsigned VAL_W = 9;

  // Width of the running hit count and its saturation value.
  localparam int unsigned COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Default size of the value universe (depth of both stores).
  localparam int unsigned UNIVERSE_DEF = 512;

  // Item action codes.
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_PROBE = 1'b1;

endpackage : ssic_pkg

`default_nettype wire

// ----- design/ssic_ram.sv -----
// ----------------------------------------------------------------------------
// ssic_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read data output. Read data holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module ssic_ram #(
  parameter int unsigned DEPTH = ssic_pkg::UNIVERSE_DEF,
  parameter int unsigned WIDTH = ssic_pkg::VAL_W
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule : ssic_ram

`default_nettype wire

// ----- design/sparse_set_intersection_counter_unit.sv -----
// ----------------------------------------------------------------------------
// sparse_set_intersection_counter_unit
// Sparse set with constant-time clear that counts how many probed values
// belong to a loaded set.
// ----------------------------------------------------------------------------
// Usage: items arrive on the input channel (in_valid_i / in_stall_o) with an
// action, a value and a last flag. An add item puts its value into the set;
// it gives no result and is dropped when the value lies outside the universe
// or the set is already full. A probe item gives one result item on the
// output channel (out_valid_o / out_stall_i): the hit flag, the running hit
// count of the round (saturating) and final_res, a copy of last. A probe
// with last set ends the round: the set is emptied and the count zeroed.
// Timing: after an add the next item may follow at once. A probe runs its
// two dependent reads in order: the sparse store gives the slot, then the
// dense store gives the entry at that slot. Its result is registered in the
// output register once that register is free. A new item is accepted in the
// cycle the previous probe completes, so a probe is not taken while the
// reads of the last one are still under way.
// Stalls: a result waits in the output register while out_stall_i is high;
// a probe that completes meanwhile holds and the input stalls.
// Reset: control state, set size and hit count clear at once. The sparse
// store is then written to zero in a pass over all UNIVERSE entries (512 by
// default) with the input stalled, so that no probe reads an undefined slot.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_set_intersection_counter_unit #(
  parameter int unsigned UNIVERSE = ssic_pkg::UNIVERSE_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         action_i,
  input  wire logic [ssic_pkg::VAL_W-1:0]   value_i,
  input  wire logic                         last_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              hit_o,
  output logic      [ssic_pkg::COUNT_W-1:0] match_count_o,
  output logic                              final_res_o
);

  // Slot index width, set size width (must hold UNIVERSE itself) and a
  // width wide enough to compare a value against the universe bound.
  localparam int unsigned SlotW = $clog2(UNIVERSE);
  localparam int unsigned SizeW = $clog2(UNIVERSE + 1);
  localparam int unsigned ExtW  =
    ((SlotW > ssic_pkg::VAL_W) ? SlotW : ssic_pkg::VAL_W) + 1;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SPARSE = 2'd1;
  localparam logic [1:0] ST_DENSE  = 2'd2;
  localparam logic [1:0] ST_CLEAR  = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [SizeW-1:0]             size_q, size_d;
  logic [ssic_pkg::COUNT_W-1:0] total_q, total_d;
  logic [SlotW-1:0]             clr_q, clr_d;

  // Probe context held while the reads are under way.
  logic [ssic_pkg::VAL_W-1:0]   val_q;
  logic                         last_q;
  logic                         in_range_q;
  logic                         slot_ok_q;

  // Output register.
  logic                         out_valid_q;
  logic                         hit_q;
  logic [ssic_pkg::COUNT_W-1:0] count_q;
  logic                         final_q;

  logic                         in_acc;
  logic                         out_free;
  logic                         load;
  logic                         clearing;
  logic                         in_range;
  logic [ExtW-1:0]              val_ext;
  logic [SizeW-1:0]             eff_size;
  logic                         do_add;
  logic                         do_probe;
  logic [SlotW-1:0]             sparse_rdata;
  logic [ssic_pkg::VAL_W-1:0]   dense_rdata;
  logic                         hit;
  logic [ssic_pkg::COUNT_W-1:0] match;

  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = (state_q == ST_DENSE) && out_free;
  assign clearing = (state_q == ST_CLEAR);

  always_comb begin
    unique case (state_q)
      ST_IDLE:  in_stall_o = 1'b0;
      ST_DENSE: in_stall_o = !out_free;
      default:  in_stall_o = 1'b1;
    endcase
  end

  assign in_acc   = in_valid_i && !in_stall_o;
  assign val_ext  = ExtW'(value_i);
  assign in_range = val_ext < ExtW'(UNIVERSE);
  assign do_probe = in_acc && (action_i == ssic_pkg::ACT_PROBE);

  // A probe that ends its round in this very cycle empties the set before a
  // following add that is accepted in the same cycle.
  assign eff_size = (load && last_q) ? '0 : size_q;
  assign do_add   = in_acc && (action_i == ssic_pkg::ACT_ADD) && in_range &&
                    (eff_size < SizeW'(UNIVERSE));

  // Sparse store: value -> slot in the dense store. The reset pass walks
  // every entry and writes slot zero.
  ssic_ram #(
    .DEPTH (UNIVERSE),
    .WIDTH (SlotW)
  ) u_sparse (
    .clk_i   (clk_i),
    .we_i    (do_add || clearing),
    .waddr_i (clearing ? clr_q : SlotW'(val_ext)),
    .wdata_i (clearing ? '0 : SlotW'(eff_size)),
    .re_i    (do_probe),
    .raddr_i (SlotW'(val_ext)),
    .rdata_o (sparse_rdata)
  );

  // Dense store: slot -> value; read at the slot that the sparse store gave.
  ssic_ram #(
    .DEPTH (UNIVERSE),
    .WIDTH (ssic_pkg::VAL_W)
  ) u_dense (
    .clk_i   (clk_i),
    .we_i    (do_add),
    .waddr_i (SlotW'(eff_size)),
    .wdata_i (value_i),
    .re_i    (state_q == ST_SPARSE),
    .raddr_i (sparse_rdata),
    .rdata_o (dense_rdata)
  );

  // The dense entry is trusted only when the slot lies below the set size,
  // so an unwritten entry never reaches the hit flag.
  assign hit   = slot_ok_q && (dense_rdata == val_q);
  assign match = (hit && (total_q != ssic_pkg::COUNT_MAX)) ?
                 total_q + 1'b1 : total_q;

  always_comb begin
    state_d = state_q;
    size_d  = eff_size;
    total_d = total_q;
    clr_d   = clr_q;
    if (do_add) begin
      size_d = eff_size + 1'b1;
    end
    if (load) begin
      total_d = last_q ? '0 : match;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (do_probe) begin
          state_d = ST_SPARSE;
        end
      end
      ST_SPARSE: begin
        state_d = ST_DENSE;
      end
      ST_DENSE: begin
        if (load) begin
          state_d = do_probe ? ST_SPARSE : ST_IDLE;
        end
      end
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == SlotW'(UNIVERSE - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      size_q      <= '0;
      total_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
      total_q <= total_d;
      clr_q   <= clr_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_probe) begin
      val_q      <= value_i;
      last_q     <= last_i;
      in_range_q <= in_range;
    end
    if (state_q == ST_SPARSE) begin
      slot_ok_q <= in_range_q && (SizeW'(sparse_rdata) < size_q);
    end
    if (load) begin
      hit_q   <= hit;
      count_q <= match;
      final_q <= last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign match_count_o = count_q;
  assign final_res_o   = final_q;

  // The set never grows beyond the universe.
  a_size_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= SizeW'(UNIVERSE))
    else $error("set size exceeds the universe");

  // No item is taken while the sparse read of a probe is outstanding.
  a_no_accept_sparse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SPARSE) |-> in_stall_o)
    else $error("item accepted during sparse read");

  // An accepted probe moves on to its sparse read in the next cycle.
  a_probe_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_probe |=> (state_q == ST_SPARSE))
    else $error("probe did not start its reads");

  // A completed last probe leaves the hit count at zero.
  a_round_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last_q) |=> (total_q == '0))
    else $error("hit count not cleared at end of round");

endmodule : sparse_set_intersection_counter_unit

`default_nettype wire
